### design/fcat_pkg.sv
// shared types, codes and constants of the four-channel alarm timer
package fcat_pkg;

  localparam int NUM_SLOTS = 4;
  localparam int CHANNELS = 4;
  localparam int TICKS_PER_UNIT = 1;
  localparam int ACTIVE_CHANNELS = (CHANNELS < NUM_SLOTS) ? CHANNELS : NUM_SLOTS;

  localparam int FUNC_W = 3;
  localparam int CH_W = 2;
  localparam int CNT_W = 32;
  localparam int CFG_IDX_W = 3;

  localparam logic [FUNC_W-1:0] FUNC_TICK    = 3'd0;
  localparam logic [FUNC_W-1:0] FUNC_START   = 3'd1;
  localparam logic [FUNC_W-1:0] FUNC_STOP    = 3'd2;
  localparam logic [FUNC_W-1:0] FUNC_RESTART = 3'd3;
  localparam logic [FUNC_W-1:0] FUNC_ACK     = 3'd4;

  localparam logic [CFG_IDX_W-1:0] REG_PERIODIC  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_IRQ_EN    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_PERIOD_0  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_PERIOD_1  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_PERIOD_2  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_PERIOD_3  = 3'd5;

  typedef struct packed {
    logic [NUM_SLOTS-1:0] periodic;
    logic [NUM_SLOTS-1:0] irq_en;
    logic [NUM_SLOTS-1:0][CNT_W-1:0] period;  // already scaled to ticks
  } cfg_t;

  typedef struct packed {
    logic [CNT_W-1:0] counter;
    logic [NUM_SLOTS-1:0] armed;
    logic [NUM_SLOTS-1:0] pending;
    logic [NUM_SLOTS-1:0] irq;
    logic [NUM_SLOTS-1:0] fired;
  } result_t;

endpackage

### design/four_channel_alarm_timer.sv
// top level of the four-channel alarm timer
// A 32-bit counter that advances on tick requests, with four compare-match alarm
// channels. Each request is a tick or a command (start, stop, restart if armed,
// acknowledge) on one channel, and each gives exactly one result holding the
// counter, armed, pending, masked irq and fired bits after it. The channel compares
// and alarm adds sit between the state registers and the result register, and a
// request is taken every cycle while the result register is empty or being drained.
// Periods are scaled to ticks when the register is written.
module four_channel_alarm_timer import fcat_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_ready,
  input  logic [FUNC_W-1:0] func,
  input  logic [CH_W-1:0] channel,
  output logic out_valid,
  input  logic out_ready,
  output logic [CNT_W-1:0] counter_now,
  output logic [NUM_SLOTS-1:0] armed_bits,
  output logic [NUM_SLOTS-1:0] pending_bits,
  output logic [NUM_SLOTS-1:0] irq_lines,
  output logic [NUM_SLOTS-1:0] fired_bits,
  input  logic cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CNT_W-1:0] cfg_data
);

  cfg_t cfg;
  result_t result, held;
  logic space, accept;

  assign in_ready = space;
  assign accept = in_valid && space;

  fcat_cfg u_cfg (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_index(cfg_index),
    .cfg_data(cfg_data), .cfg(cfg)
  );

  fcat_core u_core (
    .clk(clk), .rst(rst), .accept(accept), .func(func), .channel(channel),
    .cfg(cfg), .result(result)
  );

  fcat_out u_out (
    .clk(clk), .rst(rst), .load(accept), .result(result), .out_ready(out_ready),
    .out_valid(out_valid), .space(space), .held(held)
  );

  assign counter_now = held.counter;
  assign armed_bits = held.armed;
  assign pending_bits = held.pending;
  assign irq_lines = held.irq;
  assign fired_bits = held.fired;

endmodule

### design/fcat_cfg.sv
// configuration registers; periods are scaled to ticks as they are written
module fcat_cfg import fcat_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CNT_W-1:0] cfg_data,
  output cfg_t cfg
);

  logic [CNT_W-1:0] scaled;

  assign scaled = CNT_W'(cfg_data * CNT_W'(TICKS_PER_UNIT));

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_PERIODIC: cfg.periodic <= cfg_data[NUM_SLOTS-1:0];
        REG_IRQ_EN:   cfg.irq_en <= cfg_data[NUM_SLOTS-1:0];
        REG_PERIOD_0: cfg.period[0] <= scaled;
        REG_PERIOD_1: cfg.period[1] <= scaled;
        REG_PERIOD_2: cfg.period[2] <= scaled;
        REG_PERIOD_3: cfg.period[3] <= scaled;
        default: ;
      endcase
    end
  end

endmodule

### design/fcat_core.sv
// counter, alarm compare and channel state, updated once per accepted request
module fcat_core import fcat_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic accept,
  input  logic [FUNC_W-1:0] func,
  input  logic [CH_W-1:0] channel,
  input  cfg_t cfg,
  output result_t result
);

  logic [CNT_W-1:0] tick, tick_next, tick_inc;
  logic [NUM_SLOTS-1:0][CNT_W-1:0] alarm, alarm_next;
  logic [NUM_SLOTS-1:0] armed, armed_next;
  logic [NUM_SLOTS-1:0] pending, pending_next;
  logic [NUM_SLOTS-1:0] fired;
  logic [NUM_SLOTS-1:0] live;
  logic [CNT_W-1:0] start_value;

  always_comb begin
    for (int i = 0; i < NUM_SLOTS; i++) begin
      live[i] = (i < ACTIVE_CHANNELS);
    end
  end

  assign tick_inc = tick + CNT_W'(1);
  assign start_value = tick + cfg.period[channel];

  always_comb begin
    tick_next = tick;
    alarm_next = alarm;
    armed_next = armed;
    pending_next = pending;
    fired = '0;
    case (func)
      FUNC_TICK: begin
        tick_next = tick_inc;
        for (int i = 0; i < NUM_SLOTS; i++) begin
          if (live[i] && armed[i] && alarm[i] == tick_inc) begin
            fired[i] = 1'b1;
            pending_next[i] = 1'b1;
            if (cfg.periodic[i]) alarm_next[i] = alarm[i] + cfg.period[i];
            else armed_next[i] = 1'b0;
          end
        end
      end
      FUNC_START: begin
        if (live[channel]) begin
          alarm_next[channel] = start_value;
          armed_next[channel] = 1'b1;
        end
      end
      FUNC_STOP: begin
        if (live[channel]) armed_next[channel] = 1'b0;
      end
      FUNC_RESTART: begin
        if (live[channel] && armed[channel]) alarm_next[channel] = start_value;
      end
      FUNC_ACK: begin
        if (live[channel]) pending_next[channel] = 1'b0;
      end
      default: ;
    endcase
  end

  always_comb begin
    result.counter = tick_next;
    result.armed = armed_next;
    result.pending = pending_next;
    result.irq = pending_next & cfg.irq_en;
    result.fired = fired;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tick <= '0;
      alarm <= '0;
      armed <= '0;
      pending <= '0;
    end else if (accept) begin
      tick <= tick_next;
      alarm <= alarm_next;
      armed <= armed_next;
      pending <= pending_next;
    end
  end

endmodule

### design/fcat_out.sv
// result register with valid and ready toward the consumer
module fcat_out import fcat_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic load,
  input  result_t result,
  input  logic out_ready,
  output logic out_valid,
  output logic space,
  output result_t held
);

  // a new request may enter while the held result is being taken
  assign space = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      held <= result;
    end
  end

endmodule

### design/fcat_checker.sv
// port-level checks of the alarm timer and their binding to the top level
module fcat_checker import fcat_pkg::*; (
  input logic clk,
  input logic rst,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input logic [CNT_W-1:0] counter_now,
  input logic [NUM_SLOTS-1:0] pending_bits,
  input logic [NUM_SLOTS-1:0] irq_lines,
  input logic [NUM_SLOTS-1:0] fired_bits
);

  // a channel that fires always leaves its pending bit set
  a_fired_pending: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (fired_bits & ~pending_bits) == '0)
    else $error("fired channel without pending bit");

  a_irq_pending: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (irq_lines & ~pending_bits) == '0)
    else $error("irq line raised without pending bit");

  a_reset_empty: assert property (@(posedge clk)
    $past(rst) |-> !out_valid)
    else $error("result valid right after reset");

  // a stalled result blocks new requests and holds its value
  a_stall: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |-> !in_ready ##1 (out_valid && $stable(counter_now)))
    else $error("stalled result changed or request taken");

endmodule

bind four_channel_alarm_timer fcat_checker u_fcat_checker (
  .clk(clk), .rst(rst), .in_ready(in_ready), .out_valid(out_valid),
  .out_ready(out_ready), .counter_now(counter_now), .pending_bits(pending_bits),
  .irq_lines(irq_lines), .fired_bits(fired_bits)
);
